### rtl/trqs_pkg.sv
// Shared types and codes for the round-robin ready queue scheduler.
// Used by the queue cell, the cell row and the top level.
`default_nettype none

package trqs_pkg;

  // Thread numbers on the ports are four bits wide.
  localparam int TID_W   = 4;
  localparam int NUM_IDS = 16;
  localparam int FUNC_W  = 3;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 3;

  // Operation codes on the input channel.
  localparam logic [FUNC_W-1:0] FN_READY = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SCHED = 3'd1;
  localparam logic [FUNC_W-1:0] FN_EXIT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_KILL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_YIELD = 3'd4;

  // Action codes on the output channel.
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SWITCH = 2'd2;

  // Status codes on the output channel.
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP   = 3'd1;
  localparam logic [STAT_W-1:0] ST_LAST  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOACT = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTQ  = 3'd4;

  // Commands broadcast to every cell of the queue row.
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t OP_HOLD       = 3'd0;
  localparam cell_op_t OP_SHIFT      = 3'd1;
  localparam cell_op_t OP_LOAD       = 3'd2;
  localparam cell_op_t OP_SHIFT_LOAD = 3'd3;
  localparam cell_op_t OP_MARK       = 3'd4;
  localparam cell_op_t OP_COMPACT    = 3'd5;

  typedef struct packed {
    cell_op_t           op;
    logic [TID_W-1:0]   load_id;
    logic [TID_W-1:0]   kill_id;
  } cell_cmd_t;

  // One result item.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TID_W-1:0]  to_thread;
    logic [TID_W-1:0]  from_thread;
    logic [ACT_W-1:0]  action;
  } res_t;

endpackage

`default_nettype wire

### rtl/thread_ready_queue_scheduler.sv
// Round-robin ready queue scheduler, top level: handshakes, sequencer and result buffer.
// Depends on trqs_pkg and trqs_row.
//
// Use: each input item on s_* is one scheduler operation (ready, schedule, exit,
// kill, yield) with a thread number; each gives exactly one result item on m_*
// that says whether to start or switch threads, and a status.
// The ready queue is kept in order in a row of cells, front in the first cell.
// Timing: the result is registered when the item is accepted and then shows on
// m_tvalid. Ready, schedule, exit and yield finish when accepted. A kill marks
// the removed thread's cell as a gap, and the gap then moves one cell per cycle
// to the back of the row (the row holds at most 16 threads); s_tready stays low
// until it is gone.
// Stalls: a one-item skid buffer sits behind the output register, so one more
// item is taken while a result waits; then s_tready drops until m_tready.
// Reset: the queue is empty and no thread is running.
`default_nettype none

module thread_ready_queue_scheduler
  import trqs_pkg::*;
#(
  parameter int MAX_THREADS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // func [2:0], thread_id [6:3], zero [7]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // action, from_thread, to_thread, status, zero
);

  // Thread numbers never exceed the port width, so the row stops there.
  localparam int NCELL = (MAX_THREADS < NUM_IDS) ? MAX_THREADS : NUM_IDS;
  localparam int CW    = $clog2(NCELL + 1);

  localparam logic S_IDLE    = 1'b0;
  localparam logic S_COMPACT = 1'b1;

  logic             state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [NUM_IDS-1:0] queued, queued_next;
  logic [TID_W-1:0] run, run_next;
  logic             run_vld, run_vld_next;

  logic             out_vld;
  res_t             out_res;
  logic             pend_vld;
  res_t             pend_res;

  cell_cmd_t        cmd;
  logic [CW-1:0]    load_pos;
  logic [TID_W-1:0] head_id;
  logic             hole_any;

  logic [FUNC_W-1:0] func;
  logic [TID_W-1:0]  tid;
  logic              accept;
  logic              in_range;
  logic              q_empty;
  res_t              res;

  assign func     = s_tdata[2:0];
  assign tid      = s_tdata[6:3];
  assign s_tready = (state == S_IDLE) && !pend_vld;
  assign accept   = s_tvalid && s_tready;
  assign in_range = {28'd0, tid} < 32'(MAX_THREADS);
  assign q_empty  = (count == '0);

  trqs_row #(
    .NCELL (NCELL),
    .CW    (CW)
  ) u_row (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .load_pos (load_pos),
    .head_id  (head_id),
    .hole_any (hole_any)
  );

  // Operation decode: queue command, bookkeeping and the result item.
  always_comb begin
    state_next   = state;
    count_next   = count;
    queued_next  = queued;
    run_next     = run;
    run_vld_next = run_vld;
    cmd.op       = OP_HOLD;
    cmd.load_id  = tid;
    cmd.kill_id  = tid;
    load_pos     = count;
    res          = '0;

    if (state == S_COMPACT) begin
      cmd.op = OP_COMPACT;
      if (!hole_any) begin
        state_next = S_IDLE;
      end
    end else if (accept) begin
      unique case (func)
        FN_READY: begin
          if (!in_range) begin
            res.status = ST_NOTQ;
          end else if (queued[tid]) begin
            res.status = ST_DUP;
          end else begin
            cmd.op      = OP_LOAD;
            count_next  = count + 1'b1;
            queued_next[tid] = 1'b1;
          end
        end
        FN_SCHED: begin
          if (!q_empty) begin
            cmd.op        = OP_SHIFT;
            count_next    = count - 1'b1;
            queued_next[head_id] = 1'b0;
            res.action    = ACT_START;
            res.to_thread = head_id;
            run_next      = head_id;
            run_vld_next  = 1'b1;
          end
        end
        FN_EXIT: begin
          if (!q_empty) begin
            cmd.op        = OP_SHIFT;
            count_next    = count - 1'b1;
            queued_next[head_id] = 1'b0;
            if (run_vld) begin
              res.action      = ACT_SWITCH;
              res.from_thread = run;
            end else begin
              res.action = ACT_START;
            end
            res.to_thread = head_id;
            run_next      = head_id;
            run_vld_next  = 1'b1;
          end else begin
            res.status   = ST_LAST;
            run_vld_next = 1'b0;
          end
        end
        FN_KILL: begin
          if (!in_range || !queued[tid]) begin
            res.status = ST_NOTQ;
          end else begin
            cmd.op      = OP_MARK;
            count_next  = count - 1'b1;
            queued_next[tid] = 1'b0;
            state_next  = S_COMPACT;
          end
        end
        FN_YIELD: begin
          if (!run_vld) begin
            res.status = ST_NOACT;
          end else begin
            res.action      = ACT_SWITCH;
            res.from_thread = run;
            if (queued[run]) begin
              // Already waiting: just take the front.
              cmd.op        = OP_SHIFT;
              count_next    = count - 1'b1;
              queued_next[head_id] = 1'b0;
              res.to_thread = head_id;
              run_next      = head_id;
            end else if (q_empty) begin
              // Alone: it goes back in and comes straight out again.
              res.to_thread = run;
            end else begin
              // Take the front and put the running thread at the back.
              cmd.op        = OP_SHIFT_LOAD;
              cmd.load_id   = run;
              load_pos      = count - 1'b1;
              queued_next[head_id] = 1'b0;
              queued_next[run]     = 1'b1;
              res.to_thread = head_id;
              run_next      = head_id;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Scheduler state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      queued  <= '0;
      run     <= '0;
      run_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      queued  <= queued_next;
      run     <= run_next;
      run_vld <= run_vld_next;
    end
  end

  // Output register with a one-item skid buffer behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      if (pend_vld && (!out_vld || m_tready)) begin
        out_vld  <= 1'b1;
        pend_vld <= 1'b0;
      end else if (accept) begin
        if (!out_vld || m_tready) begin
          out_vld <= 1'b1;
        end else begin
          pend_vld <= 1'b1;
        end
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_vld && (!out_vld || m_tready)) begin
      out_res <= pend_res;
    end else if (accept) begin
      if (!out_vld || m_tready) begin
        out_res <= res;
      end else begin
        pend_res <= res;
      end
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {3'd0, out_res.status, out_res.to_thread,
                     out_res.from_thread, out_res.action};

endmodule

`default_nettype wire

### rtl/trqs_cell.sv
// One queue position of the ready queue: a thread number, a valid bit and a hole mark.
// Depends on trqs_pkg for the command struct.
`default_nettype none

module trqs_cell
  import trqs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_cmd_t        cmd,
  input  wire logic             load_sel,
  input  wire logic [TID_W-1:0] nxt_id,
  input  wire logic             nxt_vld,
  input  wire logic             prev_hole,
  output logic      [TID_W-1:0] id,
  output logic                  vld,
  output logic                  hole
);

  // Control bits: valid and the hole left behind by a removed thread.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= 1'b0;
      hole <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_SHIFT: begin
          vld <= nxt_vld;
        end
        OP_LOAD: begin
          if (load_sel) begin
            vld <= 1'b1;
          end
        end
        OP_SHIFT_LOAD: begin
          vld <= load_sel ? 1'b1 : nxt_vld;
        end
        OP_MARK: begin
          hole <= vld && (id == cmd.kill_id);
        end
        OP_COMPACT: begin
          // A hole pulls the next entry in and moves one place back.
          if (hole) begin
            vld <= nxt_vld;
          end
          hole <= prev_hole && vld;
        end
        default: begin
        end
      endcase
    end
  end

  // Thread number held in this position.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_SHIFT: begin
        id <= nxt_id;
      end
      OP_LOAD: begin
        if (load_sel) begin
          id <= cmd.load_id;
        end
      end
      OP_SHIFT_LOAD: begin
        id <= load_sel ? cmd.load_id : nxt_id;
      end
      OP_COMPACT: begin
        if (hole) begin
          id <= nxt_id;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/trqs_row.sv
// Row of queue cells that holds the ready queue in order, front in cell zero.
// Depends on trqs_pkg and trqs_cell.
`default_nettype none

module trqs_row
  import trqs_pkg::*;
#(
  parameter int NCELL = 16,
  parameter int CW    = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_cmd_t        cmd,
  input  wire logic [CW-1:0]    load_pos,
  output logic      [TID_W-1:0] head_id,
  output logic                  hole_any
);

  logic [TID_W-1:0] ids   [NCELL];
  logic [NCELL-1:0] vlds;
  logic [NCELL-1:0] holes;

  // Each cell sees its successor's entry and its predecessor's hole mark.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [TID_W-1:0] n_id;
    logic             n_vld;
    logic             p_hole;

    if (i == NCELL - 1) begin : g_last
      assign n_id  = '0;
      assign n_vld = 1'b0;
    end else begin : g_mid
      assign n_id  = ids[i+1];
      assign n_vld = vlds[i+1];
    end

    if (i == 0) begin : g_first
      assign p_hole = 1'b0;
    end else begin : g_rest
      assign p_hole = holes[i-1];
    end

    trqs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .load_sel  (load_pos == CW'(i)),
      .nxt_id    (n_id),
      .nxt_vld   (n_vld),
      .prev_hole (p_hole),
      .id        (ids[i]),
      .vld       (vlds[i]),
      .hole      (holes[i])
    );
  end

  // The front of the queue and whether a removal is still being closed up.
  assign head_id  = ids[0];
  assign hole_any = |holes;

endmodule

`default_nettype wire

### tb/sv/thread_ready_queue_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the round-robin ready queue scheduler.
// Needs trqs_pkg and the scheduler RTL (top level, row and cell), nothing else.

module thread_ready_queue_scheduler_tb;
  import trqs_pkg::*;

  localparam int MAX_THREADS  = 16;
  localparam int ITEM_TARGET  = 750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = MAX_THREADS + 4;
  localparam logic [FUNC_W-1:0] FN_TOP = '1;

  // Tracks the ready queue and the running thread, and holds the results that
  // the block still owes, oldest first.
  class ready_queue_scoreboard;
    logic [TID_W-1:0] ready_q[$];
    bit               queued[NUM_IDS];
    logic [TID_W-1:0] running_id;
    bit               running_on;
    res_t             owed_q[$];
    int               errors;
    int               checked;
    int               deepest;
    int               op_seen[8];
    int               status_seen[8];

    function new();
      running_id = '0;
      running_on = 1'b0;
      errors     = 0;
      checked    = 0;
      deepest    = 0;
    endfunction

    function void push_id(logic [TID_W-1:0] tid);
      ready_q.push_back(tid);
      queued[tid] = 1'b1;
      if (ready_q.size() > deepest) deepest = ready_q.size();
    endfunction

    function bit pop_id(output logic [TID_W-1:0] tid);
      tid = '0;
      if (ready_q.size() == 0) return 1'b0;
      tid = ready_q.pop_front();
      queued[tid] = 1'b0;
      return 1'b1;
    endfunction

    // A random thread that is not queued, or any thread if all are queued.
    function logic [TID_W-1:0] idle_id();
      logic [TID_W-1:0] pool[$];
      for (int i = 0; i < NUM_IDS; i++)
        if (!queued[i]) pool.push_back(TID_W'(i));
      if (pool.size() == 0) return TID_W'($urandom_range(0, NUM_IDS - 1));
      return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // A random queued thread, or any thread if the queue is empty.
    function logic [TID_W-1:0] queued_id();
      if (ready_q.size() == 0) return TID_W'($urandom_range(0, NUM_IDS - 1));
      return ready_q[$urandom_range(0, ready_q.size() - 1)];
    endfunction

    // Applies one accepted operation and records the result it must give.
    function void note_request(logic [FUNC_W-1:0] func, logic [TID_W-1:0] tid);
      res_t             want;
      logic [TID_W-1:0] t;
      want = '0;
      want.action = ACT_NONE;
      want.status = ST_OK;
      op_seen[func]++;
      case (func)
        FN_READY: begin
          if (queued[tid]) want.status = ST_DUP;
          else push_id(tid);
        end
        FN_SCHED: begin
          if (pop_id(t)) begin
            want.action    = ACT_START;
            want.to_thread = t;
            running_id     = t;
            running_on     = 1'b1;
          end
        end
        FN_EXIT: begin
          if (pop_id(t)) begin
            if (running_on) begin
              want.action      = ACT_SWITCH;
              want.from_thread = running_id;
            end else begin
              want.action = ACT_START;
            end
            want.to_thread = t;
            running_id     = t;
            running_on     = 1'b1;
          end else begin
            want.status = ST_LAST;
            running_on  = 1'b0;
          end
        end
        FN_KILL: begin
          if (!queued[tid]) begin
            want.status = ST_NOTQ;
          end else begin
            foreach (ready_q[i])
              if (ready_q[i] == tid) begin
                ready_q.delete(i);
                break;
              end
            queued[tid] = 1'b0;
          end
        end
        FN_YIELD: begin
          if (!running_on) begin
            want.status = ST_NOACT;
          end else begin
            // The running thread goes to the back unless it already waits there.
            if (!queued[running_id]) push_id(running_id);
            if (pop_id(t)) begin
              want.action      = ACT_SWITCH;
              want.from_thread = running_id;
              want.to_thread   = t;
              running_id       = t;
            end
          end
        end
        default: ;
      endcase
      owed_q.push_back(want);
    endfunction

    function void report_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
      end
    endfunction

    function void check_result(logic [15:0] data);
      res_t got;
      res_t want;
      got = res_t'(data[12:0]);
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata 0x%04h", $time, data);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      status_seen[got.status]++;
      report_field("action", want.action, got.action);
      report_field("from_thread", want.from_thread, got.from_thread);
      report_field("to_thread", want.to_thread, got.to_thread);
      report_field("status", want.status, got.status);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // func [2:0], thread_id [6:3], zero [7]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // action [1:0], from_thread [5:2], to_thread [9:6],
                               // status [12:10], zero [15:13]

  ready_queue_scoreboard sb = new();
  int burst_left = 0;
  int cycles = 0;

  thread_ready_queue_scheduler #(
    .MAX_THREADS(MAX_THREADS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check each accepted item and stall in modes that change now and then.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(50, 300);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 99) < 70);
        2: m_tready <= (rx_tick % 4 == 0);
        default: m_tready <= ($urandom_range(0, 99) < 25);
      endcase
    end
  end

  // Sends one operation; when the current burst is used up it starts a new one, mostly after an idle gap.
  task automatic send_op(input logic [FUNC_W-1:0] func, input logic [TID_W-1:0] tid);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(20, 60);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 8);
        gap = $urandom_range(1, 6);
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, tid, func};
    do @(posedge clk); while (!s_tready);
    sb.note_request(func, tid);
    burst_left--;
  endtask

  // Chooses a random operation; the phase leans toward filling or draining.
  task automatic pick_request(input int phase, output logic [FUNC_W-1:0] func,
                              output logic [TID_W-1:0] tid);
    int limits[3][5] = '{'{35, 45, 57, 75, 95},
                         '{70, 73, 76, 86, 95},
                         '{20, 35, 55, 75, 95}};
    int r;
    r   = $urandom_range(0, 99);
    tid = TID_W'($urandom_range(0, NUM_IDS - 1));
    if (r < limits[phase][0]) begin
      func = FN_READY;
      if ($urandom_range(0, 3) != 0) tid = sb.idle_id();
    end else if (r < limits[phase][1]) begin
      func = FN_SCHED;
    end else if (r < limits[phase][2]) begin
      func = FN_EXIT;
    end else if (r < limits[phase][3]) begin
      func = FN_KILL;
      if ($urandom_range(0, 9) < 7) tid = sb.queued_id();
    end else if (r < limits[phase][4]) begin
      func = FN_YIELD;
    end else begin
      func = FUNC_W'($urandom_range(FN_YIELD + 1, FN_TOP));
    end
  endtask

  initial begin
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  tid;
    int                counted;
    int                waited;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-queue cases first, then duplicates, kills and switches.
    send_op(FN_YIELD, 4'd6);    // nobody running
    send_op(FN_SCHED, 4'd0);    // empty queue
    send_op(FN_EXIT, 4'd0);     // last thread exits with nothing queued
    send_op(FN_KILL, 4'd5);     // not queued
    send_op(FN_READY, 4'd0);
    send_op(FN_READY, 4'd15);
    send_op(FN_READY, 4'd0);    // already queued
    send_op(FN_SCHED, 4'd9);
    send_op(FN_YIELD, 4'd0);
    send_op(FN_READY, 4'd15);   // the running thread queued again
    send_op(FN_YIELD, 4'd15);   // running thread already waits in the queue
    send_op(FN_READY, 4'd7);
    send_op(FN_READY, 4'd9);
    send_op(FN_READY, 4'd3);
    send_op(FN_KILL, 4'd9);     // middle
    send_op(FN_KILL, 4'd3);     // tail
    send_op(FN_KILL, 4'd15);    // head
    send_op(FN_READY, 4'd10);
    send_op(FN_EXIT, 4'd0);
    send_op(FN_EXIT, 4'd0);
    send_op(FN_EXIT, 4'd0);     // queue empties, nobody left running
    send_op(FN_READY, 4'd12);
    send_op(FN_EXIT, 4'd0);     // starts the front thread
    send_op(FN_YIELD, 4'd0);    // only thread switches to itself
    send_op(FUNC_W'(FN_TOP - 2), 4'd15);
    send_op(FUNC_W'(FN_TOP - 1), 4'd8);
    send_op(FN_TOP, 4'd15);

    // Random operations in balanced, filling and draining stretches.
    counted = 0;
    while (counted < ITEM_TARGET) begin
      pick_request((counted / 60) % 3, func, tid);
      send_op(func, tid);
      if (func <= FN_YIELD) counted++;
    end
    s_tvalid <= 1'b0;

    // Wait for the outstanding results, then watch for stray ones.
    waited = 0;
    while (sb.owed_q.size() != 0 && waited < CYCLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results still expected, actual none", $time, sb.owed_q.size());
    end

    $display("Ran ready %0d, schedule %0d, exit %0d, kill %0d, yield %0d, other %0d; "
             , sb.op_seen[FN_READY], sb.op_seen[FN_SCHED], sb.op_seen[FN_EXIT],
             sb.op_seen[FN_KILL], sb.op_seen[FN_YIELD],
             sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7]);
    $display("Checked %0d results: ok %0d, dup %0d, last %0d, noact %0d, notq %0d, depth %0d",
             sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_DUP],
             sb.status_seen[ST_LAST], sb.status_seen[ST_NOACT], sb.status_seen[ST_NOTQ],
             sb.deepest);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
